// ===== hw/rtl/sbdt_pkg.sv =====
// Shared types, constants and codes for the shared-buffer admission block.
// Used by sbdt_cfg, sbdt_ctrl, sbdt_dp and shared_buffer_dynamic_threshold.
// Has no dependencies of its own.
package sbdt_pkg;

	localparam int NUM_QUEUES      = 16;
	localparam int QIDX_W          = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int ALPHA_FRAC_BITS = 8;

	localparam int QI_W    = 4;
	localparam int SIZE_W  = 16;
	localparam int PKT_W   = 16;
	localparam int BYTE_W  = 30;
	localparam int MPB_W   = 14;
	localparam int ALPHA_W = 16;
	localparam int PROD_W  = ALPHA_W + BYTE_W;

	localparam logic [PKT_W-1:0]  PKT_MAX  = '1;
	localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

	localparam int PADDR_W = 5;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_BUFFER_SIZE  = 3'd0;
	localparam logic [2:0] REG_MEAN_BYTES   = 3'd1;
	localparam logic [2:0] REG_BYTES_MODE   = 3'd2;
	localparam logic [2:0] REG_DYNAMIC      = 3'd3;
	localparam logic [2:0] REG_ALPHA        = 3'd4;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef enum logic [1:0] {
		STAT_ADMIT = 2'd0,
		STAT_DROP  = 2'd1,
		STAT_DEQ   = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_DEC
	} state_t;

	typedef struct packed {
		logic [PKT_W-1:0]   buffer_size_pkts;
		logic [MPB_W-1:0]   mean_packet_bytes;
		logic               bytes_mode;
		logic               dynamic_enable;
		logic [ALPHA_W-1:0] alpha_q8;
		logic [BYTE_W-1:0]  capacity;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic calc;
		logic commit;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic [PKT_W-1:0]  queue_packets;
		logic [BYTE_W-1:0] queue_bytes;
		logic [PKT_W-1:0]  shared_packets;
		logic [BYTE_W-1:0] shared_bytes;
	} res_t;

endpackage

// ===== hw/rtl/sbdt_cfg.sv =====
// Configuration registers on an APB-style port, plus the registered capacity.
// Depends on sbdt_pkg.
module sbdt_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sbdt_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output sbdt_pkg::cfg_t             cfg
);
	import sbdt_pkg::*;

	logic [PKT_W-1:0]   buffer_size_q;
	logic [MPB_W-1:0]   mean_bytes_q;
	logic               bytes_mode_q;
	logic               dynamic_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [BYTE_W-1:0]  capacity_q;
	logic [2:0]         reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= '0;
			mean_bytes_q  <= MPB_W'(1000);
			bytes_mode_q  <= 1'b0;
			dynamic_q     <= 1'b0;
			alpha_q       <= ALPHA_W'(256);
		end else if (wr_en) begin
			case (reg_idx)
				REG_BUFFER_SIZE: buffer_size_q <= pwdata[PKT_W-1:0];
				REG_MEAN_BYTES:  mean_bytes_q  <= pwdata[MPB_W-1:0];
				REG_BYTES_MODE:  bytes_mode_q  <= pwdata[0];
				REG_DYNAMIC:     dynamic_q     <= pwdata[0];
				REG_ALPHA:       alpha_q       <= pwdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// Capacity in the selected unit, held in a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (bytes_mode_q) begin
			capacity_q <= BYTE_W'(buffer_size_q) * BYTE_W'(mean_bytes_q);
		end else begin
			capacity_q <= BYTE_W'(buffer_size_q);
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_BUFFER_SIZE: prdata = 32'(buffer_size_q);
			REG_MEAN_BYTES:  prdata = 32'(mean_bytes_q);
			REG_BYTES_MODE:  prdata = 32'(bytes_mode_q);
			REG_DYNAMIC:     prdata = 32'(dynamic_q);
			REG_ALPHA:       prdata = 32'(alpha_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.buffer_size_pkts  = buffer_size_q;
	assign cfg.mean_packet_bytes = mean_bytes_q;
	assign cfg.bytes_mode        = bytes_mode_q;
	assign cfg.dynamic_enable    = dynamic_q;
	assign cfg.alpha_q8          = alpha_q;
	assign cfg.capacity          = capacity_q;

endmodule

// ===== hw/rtl/sbdt_ctrl.sv =====
// Controller state machine: input handshake, stage sequencing, output valid.
// Depends on sbdt_pkg.
module sbdt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output sbdt_pkg::cmd_t cmd
);
	import sbdt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   can_commit;

	assign can_commit = ~out_valid_q | out_ready;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.calc    = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_DEC;
			end
			S_DEC: begin
				// The next item is taken in the same cycle as this one commits.
				if (can_commit) begin
					cmd.commit  = 1'b1;
					in_ready    = 1'b1;
					cmd.capture = in_valid;
					state_d     = in_valid ? S_CALC : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/sbdt_dp.sv =====
// Datapath: per-queue and shared counters, admission tests, result register.
// Depends on sbdt_pkg.
module sbdt_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sbdt_pkg::cmd_t            cmd,
	input  sbdt_pkg::cfg_t            cfg,
	input  logic                      func,
	input  logic [sbdt_pkg::QI_W-1:0]   queue_index,
	input  logic [sbdt_pkg::SIZE_W-1:0] packet_bytes,
	output sbdt_pkg::res_t            res
);
	import sbdt_pkg::*;

	logic [PKT_W-1:0]  q_pkt_q  [NUM_QUEUES];
	logic [BYTE_W-1:0] q_byte_q [NUM_QUEUES];
	logic [PKT_W-1:0]  sh_pkt_q;
	logic [BYTE_W-1:0] sh_byte_q;

	logic              func_q;
	logic [QI_W-1:0]   qi_q;
	logic [SIZE_W-1:0] size_q;

	logic [BYTE_W-1:0] free_s1;
	logic [BYTE_W:0]   qlen_after_s1;
	logic              base_ok_s1;

	res_t              res_q;

	logic              qvalid;
	logic [QIDX_W-1:0] idx;
	logic [PKT_W-1:0]  qp;
	logic [BYTE_W-1:0] qb;
	logic [BYTE_W-1:0] size_ext;
	logic [BYTE_W-1:0] occ;
	logic [BYTE_W:0]   occ_after;
	logic [BYTE_W:0]   qlen_after;
	logic              fits_cap;
	logic              no_ovf;
	logic              static_ok;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] thr;
	logic              admit;
	logic              do_write;
	logic [PKT_W-1:0]  qp_n;
	logic [BYTE_W-1:0] qb_n;
	logic [PKT_W-1:0]  sp_n;
	logic [BYTE_W-1:0] sb_n;
	status_t           status_n;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			qi_q   <= queue_index;
			size_q <= packet_bytes;
		end
	end

	assign qvalid   = (32'(qi_q) < NUM_QUEUES);
	assign idx      = QIDX_W'(qi_q);
	assign qp       = q_pkt_q[idx];
	assign qb       = q_byte_q[idx];
	assign size_ext = BYTE_W'(size_q);

	// First stage: occupancy tests and free space.
	always_comb begin
		occ        = cfg.bytes_mode ? sh_byte_q : BYTE_W'(sh_pkt_q);
		occ_after  = cfg.bytes_mode ? ((BYTE_W+1)'(sh_byte_q) + (BYTE_W+1)'(size_q))
		                            : ((BYTE_W+1)'(sh_pkt_q) + 1'b1);
		qlen_after = cfg.bytes_mode ? ((BYTE_W+1)'(qb) + (BYTE_W+1)'(size_q))
		                            : ((BYTE_W+1)'(qp) + 1'b1);
		fits_cap   = occ_after <= (BYTE_W+1)'(cfg.capacity);
		no_ovf     = (sh_pkt_q != PKT_MAX) &&
		             (((BYTE_W+1)'(sh_byte_q) + (BYTE_W+1)'(size_q)) <= (BYTE_W+1)'(BYTE_MAX));
		static_ok  = qlen_after <= (BYTE_W+1)'(cfg.capacity);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			free_s1       <= (cfg.capacity > occ) ? (cfg.capacity - occ) : '0;
			qlen_after_s1 <= qlen_after;
			base_ok_s1    <= qvalid & fits_cap & no_ovf & (cfg.dynamic_enable | static_ok);
		end
	end

	// Second stage: dynamic threshold and counter update.
	always_comb begin
		prod     = PROD_W'(cfg.alpha_q8) * PROD_W'(free_s1);
		thr      = prod >> ALPHA_FRAC_BITS;
		admit    = base_ok_s1 & (~cfg.dynamic_enable | (PROD_W'(qlen_after_s1) <= thr));
		qp_n     = qp;
		qb_n     = qb;
		sp_n     = sh_pkt_q;
		sb_n     = sh_byte_q;
		do_write = 1'b0;
		if (func_q == FUNC_ENQ) begin
			status_n = STAT_DROP;
			if (admit) begin
				qp_n     = qp + 1'b1;
				qb_n     = qb + size_ext;
				sp_n     = sh_pkt_q + 1'b1;
				sb_n     = sh_byte_q + size_ext;
				do_write = 1'b1;
				status_n = STAT_ADMIT;
			end
		end else begin
			status_n = STAT_EMPTY;
			if (qvalid && (qp != '0)) begin
				qp_n     = qp - 1'b1;
				qb_n     = (qb > size_ext) ? (qb - size_ext) : '0;
				sp_n     = (sh_pkt_q != '0) ? (sh_pkt_q - 1'b1) : sh_pkt_q;
				sb_n     = (sh_byte_q > size_ext) ? (sh_byte_q - size_ext) : '0;
				do_write = 1'b1;
				status_n = STAT_DEQ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				q_pkt_q[i]  <= '0;
				q_byte_q[i] <= '0;
			end
			sh_pkt_q  <= '0;
			sh_byte_q <= '0;
		end else if (cmd.commit && do_write) begin
			q_pkt_q[idx]  <= qp_n;
			q_byte_q[idx] <= qb_n;
			sh_pkt_q      <= sp_n;
			sh_byte_q     <= sb_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.status         <= status_n;
			res_q.queue_packets  <= qvalid ? qp_n : '0;
			res_q.queue_bytes    <= qvalid ? qb_n : '0;
			res_q.shared_packets <= sp_n;
			res_q.shared_bytes   <= sb_n;
		end
	end

	assign res = res_q;

endmodule

// ===== hw/rtl/shared_buffer_dynamic_threshold.sv =====
// Top level of the shared-buffer admission block with dynamic thresholds.
// Depends on sbdt_pkg, sbdt_cfg, sbdt_ctrl and sbdt_dp.
//
// Usage: each item on the s_ stream is an enqueue (s_tuser 0) or a dequeue
// (s_tuser 1) for one queue, with the packet's byte size. Exactly one result
// leaves on the m_ stream per item: the status in m_tuser and the queue and
// shared occupancy after the step in m_tdata. Registers are written over the
// APB-style port at byte addresses 0, 4, 8, 12 and 16; the user must write
// them only while no item is in flight, as the block does not enforce it.
// The block cannot take a new item before the previous one commits, since
// the counters are read, modified and written back for each item: first the
// occupancy tests and free space, then the alpha multiply, the threshold
// compare and the counter update.
// Reset clears all counters and loads the register defaults; no clearing
// pass is needed. While the receiver stalls, the finished result waits in
// the output register and one further item may still be accepted and
// processed up to its final stage, where it holds until the output frees.
module shared_buffer_dynamic_threshold (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // queue_index[3:0], packet_bytes[19:4], zero pad
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // queue_packets, queue_bytes, shared_packets, shared_bytes
	output logic [1:0]  m_tuser,   // status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sbdt_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	res_t res;

	sbdt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sbdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	sbdt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.func         (s_tuser),
		.queue_index  (s_tdata[3:0]),
		.packet_bytes (s_tdata[19:4]),
		.res          (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {4'b0000, res.shared_bytes, res.shared_packets,
	                  res.queue_bytes, res.queue_packets};

endmodule
